>>> design/learning_bridge_spanning_tree_core_macros.svh
// Assertion macros shared by the bridge core and its lookup engine.
// No dependencies; active only when SYNTHESIS is not defined.
`ifndef LEARNING_BRIDGE_SPANNING_TREE_CORE_MACROS_SVH
`define LEARNING_BRIDGE_SPANNING_TREE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LBST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbst assertion failed");
`define LBST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbst assertion failed");
`else
`define LBST_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define LBST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/lbst_pkg.sv
// Types, codes and constants of the learning bridge core.
// No dependencies.
package lbst_pkg;

   localparam int NUM_PORTS   = 8;
   localparam int PORT_BITS   = 3;
   localparam int ID_BITS     = 8;
   localparam int HOP_BITS    = 8;
   localparam int TABLE_DEPTH = 16;

   localparam logic [PORT_BITS:0] PORT_NONE = (PORT_BITS + 1)'(NUM_PORTS);
   localparam logic [ID_BITS:0]   HOP_NONE  = (ID_BITS + 1)'(1 << ID_BITS);
   localparam logic [HOP_BITS-1:0] HOPS_MAX = '1;

   typedef enum logic [1:0] {
      CMD_DATA,
      CMD_STP,
      CMD_CONNECT,
      CMD_START
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_DATA,
      KIND_ANNOUNCE
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_CONNECTED,
      STATUS_IGNORED
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_LOOKUP,
      CTL_FINISH
   } ctl_state_type;

   typedef enum logic [1:0] {
      LKP_IDLE,
      LKP_SCAN,
      LKP_LEARN
   } lkp_state_type;

   typedef struct packed {
      logic                 start;
      logic [ID_BITS-1:0]   src;
      logic [ID_BITS-1:0]   dst;
      logic [PORT_BITS-1:0] port;
   } lkp_req_type;

   typedef struct packed {
      logic                 done;
      logic                 hit;
      logic [PORT_BITS-1:0] port;
   } lkp_rsp_type;

endpackage

>>> design/lbst_lookup.sv
// Learning table with a sequential search engine: scans the filled entries
// once for source and destination, then learns the source. Uses lbst_pkg.
`include "learning_bridge_spanning_tree_core_macros.svh"
module lbst_lookup #(
   parameter int TABLE_DEPTH = lbst_pkg::TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lbst_pkg::lkp_req_type lkp_req,
   output lbst_pkg::lkp_rsp_type lkp_rsp
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IB = lbst_pkg::ID_BITS;
   localparam int PB = lbst_pkg::PORT_BITS;

   logic [IB-1:0] station_mem [TABLE_DEPTH];
   logic [PB-1:0] port_mem    [TABLE_DEPTH];

   lbst_pkg::lkp_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          done_ff, done_in;
   logic [IB-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [PB-1:0] port_ff, port_in;
   logic          src_hit_ff, src_hit_in, dst_hit_ff, dst_hit_in;
   logic [PB-1:0] dst_port_ff, dst_port_in;
   logic [IB-1:0] station_q_ff;
   logic [PB-1:0] port_q_ff;
   logic          rd_en, wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         station_mem[count_ff[AW-1:0]] <= src_ff;
         port_mem[count_ff[AW-1:0]]    <= port_ff;
      end
      if (rd_en) begin
         station_q_ff <= station_mem[idx_ff[AW-1:0]];
         port_q_ff    <= port_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbst_pkg::LKP_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
      idx_ff      <= idx_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      port_ff     <= port_in;
      src_hit_ff  <= src_hit_in;
      dst_hit_ff  <= dst_hit_in;
      dst_port_ff <= dst_port_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      done_in     = 1'b0;
      src_in      = src_ff;
      dst_in      = dst_ff;
      port_in     = port_ff;
      src_hit_in  = src_hit_ff;
      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      unique case (state_ff)
         lbst_pkg::LKP_IDLE: begin
            if (lkp_req.start) begin
               src_in     = lkp_req.src;
               dst_in     = lkp_req.dst;
               port_in    = lkp_req.port;
               idx_in     = '0;
               pend_in    = 1'b0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
               state_in   = lbst_pkg::LKP_SCAN;
            end
         end
         lbst_pkg::LKP_SCAN: begin
            // compare the entry read last cycle; keep the first destination match
            pend_in = 1'b0;
            if (pend_ff) begin
               if (station_q_ff == src_ff) begin
                  src_hit_in = 1'b1;
               end
               if (station_q_ff == dst_ff && !dst_hit_ff) begin
                  dst_hit_in  = 1'b1;
                  dst_port_in = port_q_ff;
               end
            end
            if (idx_ff < count_ff) begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = lbst_pkg::LKP_LEARN;
            end
         end
         lbst_pkg::LKP_LEARN: begin
            // append an unknown source while room is left
            if (!src_hit_ff && count_ff < CW'(TABLE_DEPTH)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (!dst_hit_ff && dst_ff == src_ff) begin
                  dst_hit_in  = 1'b1;
                  dst_port_in = port_ff;
               end
            end
            done_in  = 1'b1;
            state_in = lbst_pkg::LKP_IDLE;
         end
         default: begin
            state_in = lbst_pkg::LKP_IDLE;
         end
      endcase
   end

   assign lkp_rsp.done = done_ff;
   assign lkp_rsp.hit  = dst_hit_ff;
   assign lkp_rsp.port = dst_port_ff;

   `LBST_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH))
   `LBST_ASSERT_IMPLY(a_idx_bound, clock, reset, state_ff == lbst_pkg::LKP_SCAN, idx_ff <= count_ff)
   `LBST_ASSERT_IMPLY(a_done_idle, clock, reset, done_ff, state_ff == lbst_pkg::LKP_IDLE)

endmodule

>>> design/learning_bridge_spanning_tree_core.sv
// Learning bridge with a simplified spanning tree: port states, root election
// and egress decision. Uses lbst_pkg and lbst_lookup.
// Flow: connect, spanning tree and start commands, and data frames on an
// inactive port, go from the captured beat straight to the finish step,
// which loads the result beat once the output register is free. A data
// frame on an active port first waits in the lookup state while the table
// scan reads the learned entries (at most TABLE_DEPTH), one per cycle.
// Throughput: one beat at a time; the next beat is taken once the result
// has moved to the output register. Reset (synchronous, active high) clears
// ports, table fill and spanning tree state; the table needs no clearing pass.
`include "learning_bridge_spanning_tree_core_macros.svh"
module learning_bridge_spanning_tree_core #(
   parameter int TABLE_DEPTH = lbst_pkg::TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [lbst_pkg::PORT_BITS-1:0]      req_ingress_port,
   input  logic [lbst_pkg::ID_BITS-1:0]        req_src_id,
   input  logic [lbst_pkg::ID_BITS-1:0]        req_dst_id,
   input  logic [lbst_pkg::ID_BITS-1:0]        req_peer_root_id,
   input  logic [lbst_pkg::HOP_BITS-1:0]       req_peer_distance,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lbst_pkg::NUM_PORTS-1:0]      rsp_egress_mask,
   output logic [1:0]                          rsp_out_kind,
   output logic [lbst_pkg::ID_BITS-1:0]        rsp_announce_root,
   output logic [lbst_pkg::HOP_BITS-1:0]       rsp_announce_distance,
   output logic [lbst_pkg::PORT_BITS:0]        rsp_root_port,
   output logic [lbst_pkg::ID_BITS:0]          rsp_next_hop_id,
   output logic [1:0]                          rsp_status_code,
   // configuration: self id
   input  logic                                csr_wr_en,
   input  logic [lbst_pkg::ID_BITS-1:0]        csr_wr_data
);

   localparam int NP = lbst_pkg::NUM_PORTS;
   localparam int PB = lbst_pkg::PORT_BITS;
   localparam int IB = lbst_pkg::ID_BITS;
   localparam int HB = lbst_pkg::HOP_BITS;

   lbst_pkg::ctl_state_type state_ff, state_in;

   // captured request beat
   lbst_pkg::cmd_type cmd_ff, cmd_in;
   logic [PB-1:0] port_ff, port_in;
   logic [IB-1:0] src_ff, src_in;
   logic [IB-1:0] proot_ff, proot_in;
   logic [HB-1:0] pdist_ff, pdist_in;

   // lookup result
   logic          dhit_ff, dhit_in;
   logic [PB-1:0] dport_ff, dport_in;

   // bridge and spanning tree state
   logic [NP-1:0] active_ff, active_in;
   logic [IB-1:0] self_id_ff, self_id_in;
   logic [IB-1:0] best_root_ff, best_root_in;
   logic [HB-1:0] hops_ff, hops_in;
   logic [PB:0]   root_port_ff, root_port_in;
   logic [IB:0]   next_hop_ff, next_hop_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NP-1:0] mask_ff, mask_in;
   lbst_pkg::kind_type   kind_ff, kind_in;
   lbst_pkg::status_type status_ff, status_in;
   logic [IB-1:0] o_root_ff, o_root_in;
   logic [HB-1:0] o_dist_ff, o_dist_in;
   logic [PB:0]   o_rport_ff, o_rport_in;
   logic [IB:0]   o_nhop_ff, o_nhop_in;

   lbst_pkg::lkp_req_type lkp_req;
   lbst_pkg::lkp_rsp_type lkp_rsp;

   logic          accept;
   logic          out_free;
   logic          in_active;
   logic [NP-1:0] in_onehot;
   logic [NP-1:0] flood_mask;
   logic [HB:0]   dist_inc;
   logic [HB-1:0] new_dist;

   lbst_lookup #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_lookup (
      .clock  (clock),
      .reset  (reset),
      .lkp_req(lkp_req),
      .lkp_rsp(lkp_rsp)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // start the table scan only for a data beat arriving on an active port
   assign lkp_req.start = accept && lbst_pkg::cmd_type'(req_command) == lbst_pkg::CMD_DATA
                          && active_ff[req_ingress_port];
   assign lkp_req.src   = req_src_id;
   assign lkp_req.dst   = req_dst_id;
   assign lkp_req.port  = req_ingress_port;

   // decision terms on the captured beat
   assign in_active  = active_ff[port_ff];
   assign in_onehot  = NP'(1) << port_ff;
   assign flood_mask = active_ff & ~in_onehot;
   assign dist_inc   = {1'b0, pdist_ff} + (HB + 1)'(1);
   assign new_dist   = (pdist_ff == lbst_pkg::HOPS_MAX) ? lbst_pkg::HOPS_MAX : dist_inc[HB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbst_pkg::CTL_IDLE;
         active_ff    <= '0;
         self_id_ff   <= '0;
         best_root_ff <= '0;
         hops_ff      <= '0;
         root_port_ff <= lbst_pkg::PORT_NONE;
         next_hop_ff  <= lbst_pkg::HOP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         self_id_ff   <= self_id_in;
         best_root_ff <= best_root_in;
         hops_ff      <= hops_in;
         root_port_ff <= root_port_in;
         next_hop_ff  <= next_hop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      port_ff    <= port_in;
      src_ff     <= src_in;
      proot_ff   <= proot_in;
      pdist_ff   <= pdist_in;
      dhit_ff    <= dhit_in;
      dport_ff   <= dport_in;
      mask_ff    <= mask_in;
      kind_ff    <= kind_in;
      status_ff  <= status_in;
      o_root_ff  <= o_root_in;
      o_dist_ff  <= o_dist_in;
      o_rport_ff <= o_rport_in;
      o_nhop_ff  <= o_nhop_in;
   end

   always_comb begin
      logic [NP-1:0]        fin_mask;
      lbst_pkg::status_type fin_status;
      lbst_pkg::kind_type   fin_kind;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      port_in      = port_ff;
      src_in       = src_ff;
      proot_in     = proot_ff;
      pdist_in     = pdist_ff;
      dhit_in      = dhit_ff;
      dport_in     = dport_ff;
      active_in    = active_ff;
      self_id_in   = self_id_ff;
      best_root_in = best_root_ff;
      hops_in      = hops_ff;
      root_port_in = root_port_ff;
      next_hop_in  = next_hop_ff;
      // drop the held beat once the consumer takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mask_in      = mask_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      o_root_in    = o_root_ff;
      o_dist_in    = o_dist_ff;
      o_rport_in   = o_rport_ff;
      o_nhop_in    = o_nhop_ff;
      fin_mask     = '0;
      fin_status   = lbst_pkg::STATUS_OK;
      fin_kind     = lbst_pkg::KIND_NONE;

      unique case (state_ff)
         lbst_pkg::CTL_IDLE: begin
            if (accept) begin
               cmd_in   = lbst_pkg::cmd_type'(req_command);
               port_in  = req_ingress_port;
               src_in   = req_src_id;
               proot_in = req_peer_root_id;
               pdist_in = req_peer_distance;
               dhit_in  = 1'b0;
               state_in = lkp_req.start ? lbst_pkg::CTL_LOOKUP : lbst_pkg::CTL_FINISH;
            end
         end
         lbst_pkg::CTL_LOOKUP: begin
            // hold until the scan reports, then keep its destination answer
            if (lkp_rsp.done) begin
               dhit_in  = lkp_rsp.hit;
               dport_in = lkp_rsp.port;
               state_in = lbst_pkg::CTL_FINISH;
            end
         end
         lbst_pkg::CTL_FINISH: begin
            unique case (cmd_ff)
               lbst_pkg::CMD_DATA: begin
                  if (!in_active) begin
                     fin_status = lbst_pkg::STATUS_IGNORED;
                  end else begin
                     fin_kind = lbst_pkg::KIND_DATA;
                     // known destination: unicast if its port is up, else drop;
                     // unknown destination: flood all other active ports
                     if (dhit_ff) begin
                        fin_mask = active_ff[dport_ff] ? (NP'(1) << dport_ff) : '0;
                     end else begin
                        fin_mask = flood_mask;
                     end
                  end
               end
               lbst_pkg::CMD_STP: begin
                  if (!in_active) begin
                     fin_status = lbst_pkg::STATUS_IGNORED;
                  end else if (proot_ff <= best_root_ff) begin
                     // adopt a better root or a shorter path, and announce it
                     if (proot_ff < best_root_ff || new_dist < hops_ff) begin
                        best_root_in = proot_ff;
                        hops_in      = new_dist;
                        next_hop_in  = {1'b0, src_ff};
                        root_port_in = {1'b0, port_ff};
                        fin_mask     = flood_mask;
                        fin_kind     = lbst_pkg::KIND_ANNOUNCE;
                     end else if (pdist_ff < hops_ff ||
                                  (pdist_ff == hops_ff && src_ff < self_id_ff)) begin
                        // neighbor is a better designated bridge: block the port
                        active_in[port_ff] = 1'b0;
                     end
                  end
               end
               lbst_pkg::CMD_CONNECT: begin
                  if ({{(32 - PB){1'b0}}, port_ff} >= 32'(NP)) begin
                     fin_status = lbst_pkg::STATUS_IGNORED;
                  end else if (in_active) begin
                     fin_status = lbst_pkg::STATUS_CONNECTED;
                  end else begin
                     active_in[port_ff] = 1'b1;
                  end
               end
               lbst_pkg::CMD_START: begin
                  fin_mask = active_ff;
                  fin_kind = lbst_pkg::KIND_ANNOUNCE;
               end
               default: begin
                  fin_mask = '0;
               end
            endcase
            if (fin_mask == '0) begin
               fin_kind = lbst_pkg::KIND_NONE;
            end
            if (out_free) begin
               // commit the state update and load the result beat together
               rsp_valid_in = 1'b1;
               mask_in      = fin_mask;
               kind_in      = fin_kind;
               status_in    = fin_status;
               o_root_in    = best_root_in;
               o_dist_in    = hops_in;
               o_rport_in   = root_port_in;
               o_nhop_in    = next_hop_in;
               state_in     = lbst_pkg::CTL_IDLE;
            end else begin
               // hold: the state must not move until the beat is loaded
               active_in    = active_ff;
               best_root_in = best_root_ff;
               hops_in      = hops_ff;
               root_port_in = root_port_ff;
               next_hop_in  = next_hop_ff;
            end
         end
         default: begin
            state_in = lbst_pkg::CTL_IDLE;
         end
      endcase

      // a self id write restarts the election with this bridge as root
      if (csr_wr_en) begin
         self_id_in   = csr_wr_data;
         best_root_in = csr_wr_data;
         hops_in      = '0;
         root_port_in = lbst_pkg::PORT_NONE;
         next_hop_in  = lbst_pkg::HOP_NONE;
      end
   end

   assign req_stall             = state_ff != lbst_pkg::CTL_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_egress_mask       = mask_ff;
   assign rsp_out_kind          = kind_ff;
   assign rsp_announce_root     = o_root_ff;
   assign rsp_announce_distance = o_dist_ff;
   assign rsp_root_port         = o_rport_ff;
   assign rsp_next_hop_id       = o_nhop_ff;
   assign rsp_status_code       = status_ff;

   `LBST_ASSERT_IMPLY(a_done_in_lookup, clock, reset, lkp_rsp.done, state_ff == lbst_pkg::CTL_LOOKUP)
   `LBST_ASSERT_IMPLY(a_root_not_above_self, clock, reset, 1'b1, best_root_ff <= self_id_ff)
   `LBST_ASSERT_IMPLY(a_no_root_port_consistent, clock, reset, root_port_ff == lbst_pkg::PORT_NONE, hops_ff == '0 && next_hop_ff == lbst_pkg::HOP_NONE)

endmodule

>>> bench/learning_bridge_spanning_tree_checker.sv
// Response checker for the learning bridge core: predicts each response from
// the accepted request and self id writes, and compares field by field. Uses lbst_pkg.
`timescale 1ns / 1ps
module learning_bridge_spanning_tree_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_command,
   input  logic [lbst_pkg::PORT_BITS-1:0]   req_ingress_port,
   input  logic [lbst_pkg::ID_BITS-1:0]     req_src_id,
   input  logic [lbst_pkg::ID_BITS-1:0]     req_dst_id,
   input  logic [lbst_pkg::ID_BITS-1:0]     req_peer_root_id,
   input  logic [lbst_pkg::HOP_BITS-1:0]    req_peer_distance,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [lbst_pkg::NUM_PORTS-1:0]   rsp_egress_mask,
   input  logic [1:0]                       rsp_out_kind,
   input  logic [lbst_pkg::ID_BITS-1:0]     rsp_announce_root,
   input  logic [lbst_pkg::HOP_BITS-1:0]    rsp_announce_distance,
   input  logic [lbst_pkg::PORT_BITS:0]     rsp_root_port,
   input  logic [lbst_pkg::ID_BITS:0]       rsp_next_hop_id,
   input  logic [1:0]                       rsp_status_code,
   input  logic                             csr_wr_en,
   input  logic [lbst_pkg::ID_BITS-1:0]     csr_wr_data,
   output int unsigned                      faults,
   output int unsigned                      outstanding,
   output int unsigned                      checked
);

   localparam int NP = lbst_pkg::NUM_PORTS;
   localparam int PB = lbst_pkg::PORT_BITS;
   localparam int IB = lbst_pkg::ID_BITS;
   localparam int HB = lbst_pkg::HOP_BITS;

   localparam logic [1:0] LINK_OFF     = 2'd0;
   localparam logic [1:0] LINK_UP      = 2'd1;
   localparam logic [1:0] LINK_BLOCKED = 2'd2;

   typedef struct {
      logic [NP-1:0]        mask;
      lbst_pkg::kind_type   kind;
      logic [IB-1:0]        root;
      logic [HB-1:0]        distance;
      logic [PB:0]          rport;
      logic [IB:0]          hop;
      lbst_pkg::status_type status;
   } bridge_verdict_type;

   logic [1:0]    link_state [NP];
   logic [IB-1:0] station_id [lbst_pkg::TABLE_DEPTH];
   logic [PB-1:0] station_port [lbst_pkg::TABLE_DEPTH];
   int unsigned   stations_learned;
   logic [IB-1:0] my_id;
   logic [IB-1:0] root_id;
   logic [HB-1:0] hops;
   logic [PB:0]   uplink_port;
   logic [IB:0]   uplink_peer;

   bridge_verdict_type   pending_verdicts [$];
   int unsigned          fault_tally = 0;
   int unsigned          checked_tally = 0;

   assign faults  = fault_tally;
   assign checked = checked_tally;

   function automatic void restart_tree();
      root_id     = my_id;
      hops        = '0;
      uplink_port = lbst_pkg::PORT_NONE;
      uplink_peer = lbst_pkg::HOP_NONE;
   endfunction

   function automatic bit port_up(logic [PB-1:0] port);
      return link_state[port] == LINK_UP;
   endfunction

   function automatic int find_station(logic [IB-1:0] id);
      for (int i = 0; i < stations_learned; i++)
         if (station_id[i] == id)
            return i;
      return -1;
   endfunction

   function automatic logic [NP-1:0] flood_mask(int skip);
      logic [NP-1:0] m;
      m = '0;
      for (int p = 0; p < NP; p++)
         if (link_state[p] == LINK_UP && p != skip)
            m[p] = 1'b1;
      return m;
   endfunction

   // Apply one request to the bridge state and return the response it earns.
   function automatic bridge_verdict_type forward_decision(
      lbst_pkg::cmd_type cmd, logic [PB-1:0] port, logic [IB-1:0] src,
      logic [IB-1:0] dst, logic [IB-1:0] proot, logic [HB-1:0] pdist);
      bridge_verdict_type v;
      int                 hit;
      logic [HB-1:0]      next_dist;
      v.mask   = '0;
      v.kind   = lbst_pkg::KIND_NONE;
      v.status = lbst_pkg::STATUS_OK;
      case (cmd)
         lbst_pkg::CMD_DATA: begin
            if (!port_up(port)) begin
               v.status = lbst_pkg::STATUS_IGNORED;
            end else begin
               if (find_station(src) < 0 && stations_learned < lbst_pkg::TABLE_DEPTH) begin
                  station_id[stations_learned]   = src;
                  station_port[stations_learned] = port;
                  stations_learned++;
               end
               hit = find_station(dst);
               if (hit < 0)
                  v.mask = flood_mask(port);
               else if (port_up(station_port[hit]))
                  v.mask[station_port[hit]] = 1'b1;
               v.kind = lbst_pkg::KIND_DATA;
            end
         end
         lbst_pkg::CMD_STP: begin
            if (!port_up(port)) begin
               v.status = lbst_pkg::STATUS_IGNORED;
            end else if (proot <= root_id) begin
               next_dist = (pdist == lbst_pkg::HOPS_MAX) ? lbst_pkg::HOPS_MAX : pdist + 1'b1;
               if (proot < root_id || next_dist < hops) begin
                  root_id     = proot;
                  hops        = next_dist;
                  uplink_peer = {1'b0, src};
                  uplink_port = {1'b0, port};
                  v.mask      = flood_mask(port);
                  v.kind      = lbst_pkg::KIND_ANNOUNCE;
               end else if (pdist < hops || (pdist == hops && src < my_id)) begin
                  link_state[port] = LINK_BLOCKED;
               end
            end
         end
         lbst_pkg::CMD_CONNECT: begin
            if (link_state[port] == LINK_UP)
               v.status = lbst_pkg::STATUS_CONNECTED;
            else
               link_state[port] = LINK_UP;
         end
         default: begin
            v.mask = flood_mask(NP);
            v.kind = lbst_pkg::KIND_ANNOUNCE;
         end
      endcase
      if (v.mask == '0)
         v.kind = lbst_pkg::KIND_NONE;
      v.root     = root_id;
      v.distance = hops;
      v.rport    = uplink_port;
      v.hop      = uplink_peer;
      return v;
   endfunction

   task automatic check_field(string field, logic [IB:0] want, logic [IB:0] got);
      if (got !== want) begin
         fault_tally++;
         $display("%t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      bridge_verdict_type want;
      if (reset) begin
         foreach (link_state[p])
            link_state[p] = LINK_OFF;
         stations_learned = 0;
         my_id            = '0;
         restart_tree();
         pending_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            my_id = csr_wr_data;
            restart_tree();
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               fault_tally++;
               $display("%t: response beat with nothing expected, got mask %h kind %h",
                        $time, rsp_egress_mask, rsp_out_kind);
            end else begin
               want = pending_verdicts.pop_front();
               checked_tally++;
               check_field("egress_mask", 9'(want.mask), 9'(rsp_egress_mask));
               check_field("out_kind", 9'(want.kind), 9'(rsp_out_kind));
               check_field("announce_root", 9'(want.root), 9'(rsp_announce_root));
               check_field("announce_distance", 9'(want.distance), 9'(rsp_announce_distance));
               check_field("root_port", 9'(want.rport), 9'(rsp_root_port));
               check_field("next_hop_id", want.hop, rsp_next_hop_id);
               check_field("status_code", 9'(want.status), 9'(rsp_status_code));
            end
         end
         if (req_valid && !req_stall)
            pending_verdicts.push_back(forward_decision(lbst_pkg::cmd_type'(req_command),
               req_ingress_port, req_src_id, req_dst_id, req_peer_root_id,
               req_peer_distance));
      end
      outstanding <= pending_verdicts.size();
   end

endmodule

>>> bench/learning_bridge_spanning_tree_core_tb.sv
// Top level of the learning bridge bench: clock, reset, request and self id
// stimulus, verdict. Uses lbst_pkg, the core and learning_bridge_spanning_tree_checker.
`timescale 1ns / 1ps
module learning_bridge_spanning_tree_core_tb;

   localparam int NP = lbst_pkg::NUM_PORTS;
   localparam int PB = lbst_pkg::PORT_BITS;
   localparam int IB = lbst_pkg::ID_BITS;
   localparam int HB = lbst_pkg::HOP_BITS;

   // Phase 0 carries the directed beats; every later phase is random.
   localparam int PHASES          = 7;
   localparam int BEATS_PER_PHASE = 150;
   localparam int CALM_PHASE      = 3;
   // A data frame scans at most TABLE_DEPTH entries, plus its setup steps.
   localparam int DRAIN_CYCLES    = lbst_pkg::TABLE_DEPTH + 8;
   // Slowest beat: long sender gap, full table scan, long response stall;
   // the limit takes that several times over.
   localparam int QUIET_LIMIT     = 1000;
   localparam int POOL_SIZE       = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lbst_pkg::cmd_type    req_command = lbst_pkg::CMD_DATA;
   logic [PB-1:0]        req_ingress_port = '0;
   logic [IB-1:0]        req_src_id = '0;
   logic [IB-1:0]        req_dst_id = '0;
   logic [IB-1:0]        req_peer_root_id = '0;
   logic [HB-1:0]        req_peer_distance = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [NP-1:0]        rsp_egress_mask;
   logic [1:0]           rsp_out_kind;
   logic [IB-1:0]        rsp_announce_root;
   logic [HB-1:0]        rsp_announce_distance;
   logic [PB:0]          rsp_root_port;
   logic [IB:0]          rsp_next_hop_id;
   logic [1:0]           rsp_status_code;
   logic                 csr_wr_en = 1'b0;
   logic [IB-1:0]        csr_wr_data = '0;

   int unsigned          faults;
   int unsigned          outstanding;
   int unsigned          checked;

   // Set for one whole phase: neither side idles nor stalls then.
   logic                 calm = 1'b0;
   int unsigned          quiet_cycles = 0;
   int unsigned          cmd_tally [4] = '{default: 0};

   learning_bridge_spanning_tree_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_ingress_port      (req_ingress_port),
      .req_src_id            (req_src_id),
      .req_dst_id            (req_dst_id),
      .req_peer_root_id      (req_peer_root_id),
      .req_peer_distance     (req_peer_distance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_egress_mask       (rsp_egress_mask),
      .rsp_out_kind          (rsp_out_kind),
      .rsp_announce_root     (rsp_announce_root),
      .rsp_announce_distance (rsp_announce_distance),
      .rsp_root_port         (rsp_root_port),
      .rsp_next_hop_id       (rsp_next_hop_id),
      .rsp_status_code       (rsp_status_code),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   learning_bridge_spanning_tree_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_ingress_port      (req_ingress_port),
      .req_src_id            (req_src_id),
      .req_dst_id            (req_dst_id),
      .req_peer_root_id      (req_peer_root_id),
      .req_peer_distance     (req_peer_distance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_egress_mask       (rsp_egress_mask),
      .rsp_out_kind          (rsp_out_kind),
      .rsp_announce_root     (rsp_announce_root),
      .rsp_announce_distance (rsp_announce_distance),
      .rsp_root_port         (rsp_root_port),
      .rsp_next_hop_id       (rsp_next_hop_id),
      .rsp_status_code       (rsp_status_code),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .faults                (faults),
      .outstanding           (outstanding),
      .checked               (checked)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Stall the response channel at random, with a chance of 37 in a hundred, except in the calm phase.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 37);
   end

   // Count cycles in which no beat moves on any port; give up past the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request beat and hold it until accepted. Valid stays high on
   // return, so a back-to-back beat just swaps the payload; an idle gap drops it first.
   task automatic send_beat(lbst_pkg::cmd_type cmd, logic [PB-1:0] port,
                            logic [IB-1:0] src, logic [IB-1:0] dst,
                            logic [IB-1:0] proot, logic [HB-1:0] pdist);
      if (!calm && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while (!calm && $urandom_range(0, 99) < 37);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_ingress_port  <= port;
      req_src_id        <= src;
      req_dst_id        <= dst;
      req_peer_root_id  <= proot;
      req_peer_distance <= pdist;
      cmd_tally[cmd]++;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   initial begin
      logic [IB-1:0]     id_plan [PHASES];
      logic [IB-1:0]     station_pool [POOL_SIZE];
      logic [IB-1:0]     root_hint;
      logic [IB-1:0]     src;
      logic [IB-1:0]     dst;
      logic [IB-1:0]     proot;
      logic [HB-1:0]     pdist;
      lbst_pkg::cmd_type cmd;
      int unsigned       pick;

      // Self id settings: both extremes, the alternating patterns, two random.
      id_plan = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h5A, 8'hFF, 8'h00};
      id_plan[3] = 8'($urandom_range(0, 255));
      id_plan[6] = 8'($urandom_range(0, 255));
      // More stations than table entries, so the table fills and then refuses.
      for (int i = 0; i < POOL_SIZE; i++)
         station_pool[i] = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         // Write the self id while the core is idle; it restarts the tree.
         csr_wr_en   <= 1'b1;
         csr_wr_data <= id_plan[phase];
         calm        <= (phase == CALM_PHASE);
         root_hint    = id_plan[phase];
         @(posedge clock);
         csr_wr_en   <= 1'b0;

         if (phase == 0) begin
            // Frames on a dead port are ignored; start with no live port sends nothing.
            send_beat(lbst_pkg::CMD_DATA, 3'd0, 8'h11, 8'h22, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_STP, 3'd2, 8'h10, 8'h00, 8'h01, 8'h00);
            send_beat(lbst_pkg::CMD_START, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
            // Bring up ports 0, 3, 5 and 7; connecting 0 twice reports it is up.
            send_beat(lbst_pkg::CMD_CONNECT, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_CONNECT, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            send_beat(lbst_pkg::CMD_CONNECT, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_CONNECT, 3'd3, 8'h00, 8'h00, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_CONNECT, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00);
            // Unknown destination floods; known one forwards, even back on ingress.
            send_beat(lbst_pkg::CMD_DATA, 3'd0, 8'h00, 8'hFF, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_DATA, 3'd7, 8'hFF, 8'h00, 8'hFF, 8'hFF);
            send_beat(lbst_pkg::CMD_DATA, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_DATA, 3'd5, 8'h55, 8'hAA, 8'h00, 8'h00);
            // Better root with the largest distance: hops saturate.
            send_beat(lbst_pkg::CMD_STP, 3'd3, 8'h33, 8'h00, 8'h10, 8'hFF);
            // Same root, no shorter path, but peer is closer: block port 5.
            send_beat(lbst_pkg::CMD_STP, 3'd5, 8'h44, 8'h00, 8'h10, 8'hFE);
            send_beat(lbst_pkg::CMD_DATA, 3'd5, 8'h55, 8'h00, 8'h00, 8'h00);
            // Destination learned on the blocked port: drop, no flood.
            send_beat(lbst_pkg::CMD_DATA, 3'd0, 8'h00, 8'h55, 8'h00, 8'h00);
            // Worse root is ignored; same root at distance 0 shortens the path.
            send_beat(lbst_pkg::CMD_STP, 3'd7, 8'h77, 8'h00, 8'h20, 8'h00);
            send_beat(lbst_pkg::CMD_STP, 3'd7, 8'h77, 8'h00, 8'h10, 8'h00);
            send_beat(lbst_pkg::CMD_STP, 3'd0, 8'h01, 8'h00, 8'h10, 8'h00);
            // Equal distance, lower peer id than ours: block on the tie.
            send_beat(lbst_pkg::CMD_STP, 3'd3, 8'h01, 8'h00, 8'h10, 8'h01);
            // Connect revives a blocked port.
            send_beat(lbst_pkg::CMD_CONNECT, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00);
            send_beat(lbst_pkg::CMD_START, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            send_beat(lbst_pkg::CMD_STP, 3'd7, 8'hFF, 8'h00, 8'hFF, 8'hFF);
            send_beat(lbst_pkg::CMD_DATA, 3'd7, 8'h80, 8'h7F, 8'h00, 8'h00);
         end else begin
            repeat (BEATS_PER_PHASE) begin
               pick = $urandom_range(0, 99);
               cmd  = (pick < 50) ? lbst_pkg::CMD_DATA : (pick < 75) ? lbst_pkg::CMD_STP :
                      (pick < 88) ? lbst_pkg::CMD_CONNECT : lbst_pkg::CMD_START;
               // Mostly pool stations, so lookups hit and the table fills.
               src = ($urandom_range(0, 99) < 70) ?
                     station_pool[$urandom_range(0, POOL_SIZE - 1)] : 8'($urandom_range(0, 255));
               dst = ($urandom_range(0, 99) < 60) ?
                     station_pool[$urandom_range(0, POOL_SIZE - 1)] : 8'($urandom_range(0, 255));
               // Aim root claims at or near the current root to reach ties and blocking.
               pick  = $urandom_range(0, 99);
               proot = (pick < 40) ? root_hint :
                       (pick < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
               pick  = $urandom_range(0, 99);
               pdist = (pick < 40) ? 8'($urandom_range(0, 3)) :
                       (pick < 60) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 255));
               if (cmd == lbst_pkg::CMD_STP && proot < root_hint)
                  root_hint = proot;
               send_beat(cmd, 3'($urandom_range(0, NP - 1)), src, dst, proot, pdist);
            end
         end

         // Drop valid and drain every response before the next self id write.
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while (outstanding != 0);
      end

      calm <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d data, %0d spanning tree, %0d connect, %0d start)",
               cmd_tally[lbst_pkg::CMD_DATA] + cmd_tally[lbst_pkg::CMD_STP] +
               cmd_tally[lbst_pkg::CMD_CONNECT] + cmd_tally[lbst_pkg::CMD_START],
               cmd_tally[lbst_pkg::CMD_DATA], cmd_tally[lbst_pkg::CMD_STP],
               cmd_tally[lbst_pkg::CMD_CONNECT], cmd_tally[lbst_pkg::CMD_START]);
      $display("across %0d self id settings; %0d responses compared, %0d mismatches",
               PHASES, checked, faults);
      if (faults == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
